### rtl/csma_pkg.sv
// ----------------------------------------------------------------------------
// csma_pkg
// Shared types and constants for the CSMA/CD station backoff block.
// ----------------------------------------------------------------------------
package csma_pkg;

  // event codes carried by an input item
  typedef enum logic [1:0] {
    OP_SLOT      = 2'd0,
    OP_COLLISION = 2'd1,
    OP_SUCCESS   = 2'd2,
    OP_ADVANCE   = 2'd3
  } op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_BACKOFF_LIMIT     = 2'd0,
    CFG_PERSIST_THRESHOLD = 2'd1,
    CFG_FRAME_COUNT       = 2'd2
  } cfg_idx_e;

  // field widths
  localparam int unsigned AttemptW   = 4;
  localparam int unsigned WaitW      = 15;
  localparam int unsigned CooldownW  = 3;
  localparam int unsigned FrameW     = 8;
  localparam int unsigned CountW     = 16;
  localparam int unsigned SlotW      = 32;
  localparam int unsigned RandPW     = 16;
  localparam int unsigned ThreshW    = 17;
  localparam int unsigned CfgDataW   = 17;

  // hard cap on backoff attempts before a drop, at most what attempt can hold
  localparam int unsigned MaxBackoffLimit = 15;
  localparam logic [AttemptW-1:0] LimitCap =
    AttemptW'((MaxBackoffLimit > 15) ? 15 : MaxBackoffLimit);

  // slot ticks skipped after a drop
  localparam logic [CooldownW-1:0] DropCooldown = 3'd5;

  // reset values of the configuration registers
  localparam logic [AttemptW-1:0] BackoffLimitRst   = 4'd15;
  localparam logic [ThreshW-1:0]  PersistThreshRst  = 17'd32768;
  localparam logic [FrameW-1:0]   FrameCountRst     = 8'd0;

endpackage

### rtl/csma_evt_if.sv
// ----------------------------------------------------------------------------
// csma_evt_if / csma_res_if
// Valid/ready channels for station events and per-event results.
// ----------------------------------------------------------------------------
interface csma_evt_if;
  logic                        valid;
  logic                        ready;
  csma_pkg::op_e               op;
  logic                        channel_busy;
  logic [15:0]                 rand_persist;
  logic [14:0]                 rand_backoff;
  logic [31:0]                 slot_now;

  modport source (output valid, op, channel_busy, rand_persist, rand_backoff, slot_now,
                  input ready);
  modport sink   (input valid, op, channel_busy, rand_persist, rand_backoff, slot_now,
                  output ready);
endinterface

interface csma_res_if;
  logic        valid;
  logic        ready;
  logic        transmit;
  logic        drop_signal;
  logic [7:0]  frames_left;
  logic [3:0]  attempt_count;
  logic [14:0] wait_left;
  logic        jam_flag;
  logic [15:0] collision_total;
  logic [15:0] drop_total;
  logic [31:0] frame_start;

  modport source (output valid, transmit, drop_signal, frames_left, attempt_count,
                  wait_left, jam_flag, collision_total, drop_total, frame_start,
                  input ready);
  modport sink   (input valid, transmit, drop_signal, frames_left, attempt_count,
                  wait_left, jam_flag, collision_total, drop_total, frame_start,
                  output ready);
endinterface

### rtl/csma_cd_station_backoff.sv
// Result path: an accepted input is held in the input register, then in the result register.
// Throughput: one item per cycle while the result side is not stalled; the station state update is a single pass of
// counter and compare logic between the input register and the result register.
// A stalled result register holds one item and the input register one more.
// Reset: asynchronous, active low; state counters clear to zero and the
// configuration registers take their defaults.
// ----------------------------------------------------------------------------
// csma_cd_station_backoff
// CSMA/CD station with p-persistence and binary exponential backoff, one
// event per item and one result per item.
// ----------------------------------------------------------------------------
module csma_cd_station_backoff (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  csma_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [csma_pkg::CfgDataW-1:0] cfg_data_i,
  csma_evt_if.sink                      evt_i,
  csma_res_if.source                    res_o
);
  import csma_pkg::*;

  // configuration registers
  logic [AttemptW-1:0] backoff_limit_q;
  logic [ThreshW-1:0]  persist_thresh_q;
  logic [FrameW-1:0]   frame_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backoff_limit_q  <= BackoffLimitRst;
      persist_thresh_q <= PersistThreshRst;
      frame_count_q    <= FrameCountRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BACKOFF_LIMIT:     backoff_limit_q  <= cfg_data_i[AttemptW-1:0];
        CFG_PERSIST_THRESHOLD: persist_thresh_q <= cfg_data_i[ThreshW-1:0];
        CFG_FRAME_COUNT:       frame_count_q    <= cfg_data_i[FrameW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic in_valid_q, out_valid_q;
  logic out_load;

  assign out_load    = in_valid_q && (!out_valid_q || res_o.ready);
  assign evt_i.ready = !in_valid_q || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (evt_i.ready) in_valid_q <= evt_i.valid;
      if (out_load) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
    end
  end

  // input register
  op_e               op_q;
  logic              busy_q;
  logic [RandPW-1:0] rand_p_q;
  logic [WaitW-1:0]  rand_b_q;
  logic [SlotW-1:0]  now_q;

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      op_q     <= evt_i.op;
      busy_q   <= evt_i.channel_busy;
      rand_p_q <= evt_i.rand_persist;
      rand_b_q <= evt_i.rand_backoff;
      now_q    <= evt_i.slot_now;
    end
  end

  // station state
  logic [AttemptW-1:0]  attempt_q, attempt_d;
  logic [WaitW-1:0]     wait_q, wait_d;
  logic [CooldownW-1:0] cooldown_q, cooldown_d;
  logic                 jam_q, jam_d;
  logic                 sending_q, sending_d;
  logic [FrameW-1:0]    head_q, head_d;
  logic [CountW-1:0]    coll_q, coll_d;
  logic [CountW-1:0]    drops_q, drops_d;
  logic [SlotW-1:0]     start_q, start_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attempt_q  <= '0;
      wait_q     <= '0;
      cooldown_q <= '0;
      jam_q      <= 1'b0;
      sending_q  <= 1'b0;
      head_q     <= '0;
      coll_q     <= '0;
      drops_q    <= '0;
      start_q    <= '0;
    end else if (out_load) begin
      attempt_q  <= attempt_d;
      wait_q     <= wait_d;
      cooldown_q <= cooldown_d;
      jam_q      <= jam_d;
      sending_q  <= sending_d;
      head_q     <= head_d;
      coll_q     <= coll_d;
      drops_q    <= drops_d;
      start_q    <= start_d;
    end
  end

  // backoff terms shared by slot and collision events
  logic [AttemptW-1:0] eff_limit;
  logic                bo_retry;
  logic [AttemptW-1:0] bo_attempt;
  logic [WaitW:0]      bo_span;
  logic [WaitW-1:0]    bo_wait;
  logic [CountW-1:0]   drops_sat;
  logic [CountW-1:0]   coll_sat;
  logic                have_frames;
  logic [FrameW-1:0]   head_next;

  assign eff_limit  = (backoff_limit_q < LimitCap) ? backoff_limit_q : LimitCap;
  assign bo_retry   = attempt_q < eff_limit;
  assign bo_attempt = attempt_q + AttemptW'(1);
  assign bo_span    = ((WaitW+1)'(1) << bo_attempt) - (WaitW+1)'(1);
  assign bo_wait    = rand_b_q & bo_span[WaitW-1:0];
  assign drops_sat  = (&drops_q) ? drops_q : drops_q + CountW'(1);
  assign coll_sat   = (&coll_q) ? coll_q : coll_q + CountW'(1);
  assign have_frames = head_q < frame_count_q;
  assign head_next  = head_q + FrameW'(1);

  // event update
  logic tx, dropped, do_backoff, do_advance;
  logic [FrameW-1:0] frames_left;

  always_comb begin
    attempt_d  = attempt_q;
    wait_d     = wait_q;
    cooldown_d = cooldown_q;
    jam_d      = jam_q;
    sending_d  = sending_q;
    head_d     = head_q;
    coll_d     = coll_q;
    drops_d    = drops_q;
    start_d    = start_q;
    tx         = 1'b0;
    dropped    = 1'b0;
    do_backoff = 1'b0;
    do_advance = 1'b0;

    case (op_q)
      OP_SLOT: begin
        if (have_frames && !sending_q) begin
          if (cooldown_q != '0) begin
            cooldown_d = cooldown_q - CooldownW'(1);
          end else if (wait_q == '0 && !busy_q) begin
            if ({1'b0, rand_p_q} < persist_thresh_q) begin
              tx        = 1'b1;
              sending_d = 1'b1;
            end
          end else if (wait_q != '0) begin
            wait_d = wait_q - WaitW'(1);
          end else begin
            do_backoff = 1'b1;
          end
        end
      end
      OP_COLLISION: begin
        jam_d      = 1'b1;
        sending_d  = 1'b0;
        coll_d     = coll_sat;
        do_backoff = 1'b1;
      end
      OP_SUCCESS: begin
        sending_d  = 1'b0;
        attempt_d  = '0;
        do_advance = 1'b1;
      end
      OP_ADVANCE: begin
        do_advance = 1'b1;
      end
      default: ;
    endcase

    // backoff: retry with a fresh random wait or drop the head frame
    if (do_backoff) begin
      if (bo_retry) begin
        attempt_d = bo_attempt;
        wait_d    = bo_wait;
      end else begin
        attempt_d  = '0;
        cooldown_d = DropCooldown;
        drops_d    = drops_sat;
        dropped    = 1'b1;
      end
    end

    // head of line moves on; record start slot when a frame remains
    if (do_advance && have_frames) begin
      head_d = head_next;
      if (head_next < frame_count_q) start_d = now_q;
    end

    frames_left = (head_d < frame_count_q) ? frame_count_q - head_d : '0;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_o.transmit        <= tx;
      res_o.drop_signal     <= dropped;
      res_o.frames_left     <= frames_left;
      res_o.attempt_count   <= attempt_d;
      res_o.wait_left       <= wait_d;
      res_o.jam_flag        <= jam_d;
      res_o.collision_total <= coll_d;
      res_o.drop_total      <= drops_d;
      res_o.frame_start     <= start_d;
    end
  end

  assign res_o.valid = out_valid_q;

endmodule

### tb/tb_csma_cd_station_backoff.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_csma_cd_station_backoff
// Self-checking bench for the CSMA/CD station: events go in through a queued
// valid/ready driver with random gaps, results are taken by a monitor with
// random stalls and compared against an in-bench station predictor.
// ----------------------------------------------------------------------------
module tb_csma_cd_station_backoff;
  import csma_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned ReportMax  = 10;

  // one event as pushed to the driver
  typedef struct packed {
    op_e         op;
    logic        busy;
    logic [15:0] rand_p;
    logic [14:0] rand_b;
    logic [31:0] slot;
  } event_t;

  // station status as carried by one result
  typedef struct packed {
    logic        transmit;
    logic        dropped;
    logic [7:0]  frames_left;
    logic [3:0]  attempt;
    logic [14:0] wait_left;
    logic        jam;
    logic [15:0] collisions;
    logic [15:0] drops;
    logic [31:0] frame_start;
  } status_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we   = 1'b0;
  cfg_idx_e            cfg_idx  = CFG_BACKOFF_LIMIT;
  logic [CfgDataW-1:0] cfg_data = '0;

  logic   drv_valid = 1'b0;
  event_t drv_item  = '0;
  logic   res_rdy   = 1'b0;

  bit idle_on = 1'b1;
  int send_gap = 0;
  int stall_left = 0;
  int mismatches = 0;
  int unsigned cycles = 0;

  event_t  event_q[$];
  status_t pending_status[$];
  status_t got;
  status_t want;

  // predictor copy of the configuration
  logic [AttemptW-1:0] lim_cfg = BackoffLimitRst;
  logic [ThreshW-1:0]  thr_cfg = PersistThreshRst;
  logic [FrameW-1:0]   fc_cfg  = FrameCountRst;

  // predictor copy of the station state
  logic [AttemptW-1:0]  k_att     = '0;
  logic [WaitW-1:0]     wait_cnt  = '0;
  logic [CooldownW-1:0] cool      = '0;
  logic                 jam_q     = 1'b0;
  logic                 sending_q = 1'b0;
  logic [FrameW-1:0]    head_q    = '0;
  logic [CountW-1:0]    coll_q    = '0;
  logic [CountW-1:0]    drop_q    = '0;
  logic [SlotW-1:0]     start_q   = '0;

  csma_evt_if evt_if ();
  csma_res_if res_if ();

  assign evt_if.valid        = drv_valid;
  assign evt_if.op           = drv_item.op;
  assign evt_if.channel_busy = drv_item.busy;
  assign evt_if.rand_persist = drv_item.rand_p;
  assign evt_if.rand_backoff = drv_item.rand_b;
  assign evt_if.slot_now     = drv_item.slot;
  assign res_if.ready        = res_rdy;

  csma_cd_station_backoff DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .evt_i      (evt_if),
    .res_o      (res_if)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [FrameW-1:0] frames_ahead();
    return (head_q >= fc_cfg) ? '0 : fc_cfg - head_q;
  endfunction

  function automatic logic [CountW-1:0] sat_inc(logic [CountW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // returns 1 when the head frame is dropped
  function automatic logic backoff_step(logic [WaitW-1:0] rb);
    logic [AttemptW-1:0] cap;
    cap = (lim_cfg > LimitCap) ? LimitCap : lim_cfg;
    if (k_att < cap) begin
      k_att    = k_att + 1'b1;
      wait_cnt = rb & WaitW'((32'd1 << k_att) - 32'd1);
      return 1'b0;
    end
    k_att  = '0;
    cool   = DropCooldown;
    drop_q = sat_inc(drop_q);
    return 1'b1;
  endfunction

  function automatic void advance_head(logic [SlotW-1:0] now);
    if (head_q < fc_cfg) begin
      head_q = head_q + 1'b1;
      if (head_q < fc_cfg) start_q = now;
    end
  endfunction

  function automatic status_t station_next(event_t e);
    status_t r;
    logic    tx;
    logic    dropped;
    tx      = 1'b0;
    dropped = 1'b0;
    case (e.op)
      OP_SLOT: begin
        if (frames_ahead() != 0 && !sending_q) begin
          if (cool != 0) begin
            cool = cool - 1'b1;
          end else if (wait_cnt == 0 && !e.busy) begin
            if ({1'b0, e.rand_p} < thr_cfg) begin
              tx        = 1'b1;
              sending_q = 1'b1;
            end
          end else if (wait_cnt != 0) begin
            wait_cnt = wait_cnt - 1'b1;
          end else begin
            dropped = backoff_step(e.rand_b);
          end
        end
      end
      OP_COLLISION: begin
        jam_q     = 1'b1;
        sending_q = 1'b0;
        dropped   = backoff_step(e.rand_b);
        coll_q    = sat_inc(coll_q);
      end
      OP_SUCCESS: begin
        sending_q = 1'b0;
        k_att     = '0;
        advance_head(e.slot);
      end
      default: begin
        advance_head(e.slot);
      end
    endcase
    r.transmit    = tx;
    r.dropped     = dropped;
    r.frames_left = frames_ahead();
    r.attempt     = k_att;
    r.wait_left   = wait_cnt;
    r.jam         = jam_q;
    r.collisions  = coll_q;
    r.drops       = drop_q;
    r.frame_start = start_q;
    return r;
  endfunction

  function automatic string show_status(status_t s);
    return $sformatf("tx=%0b drop=%0b left=%0d k=%0d wait=%0d jam=%0b coll=%0d drops=%0d start=%h",
                     s.transmit, s.dropped, s.frames_left, s.attempt, s.wait_left, s.jam,
                     s.collisions, s.drops, s.frame_start);
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic void add_event(op_e op, logic busy, logic [15:0] rp, logic [14:0] rb,
                                    logic [31:0] slot);
    event_t e;
    e.op     = op;
    e.busy   = busy;
    e.rand_p = rp;
    e.rand_b = rb;
    e.slot   = slot;
    event_q.push_back(e);
  endfunction

  function automatic void add_random(op_e op, logic busy);
    add_event(op, busy, 16'($urandom), 15'($urandom), 32'($urandom));
  endfunction

  // one frame's life: ticks, collisions and the odd success or advance, closed by success or advance
  function automatic int make_episode();
    int n;
    int r;
    n = $urandom_range(2, 24);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 72) add_random(OP_SLOT, 1'($urandom_range(0, 2) == 0));
      else if (r < 92) add_random(OP_COLLISION, 1'($urandom_range(0, 1)));
      else if (r < 96) add_random(OP_SUCCESS, 1'($urandom_range(0, 1)));
      else add_random(OP_ADVANCE, 1'($urandom_range(0, 1)));
    end
    add_random(($urandom_range(0, 2) == 0) ? OP_ADVANCE : OP_SUCCESS, 1'($urandom_range(0, 1)));
    return n + 1;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BACKOFF_LIMIT:     lim_cfg = data[AttemptW-1:0];
      CFG_PERSIST_THRESHOLD: thr_cfg = data[ThreshW-1:0];
      default:               fc_cfg  = data[FrameW-1:0];
    endcase
  endtask

  // hold the sender until every expected result is back, then let it settle
  task automatic drain();
    do @(negedge clk_i);
    while (event_q.size() != 0 || pending_status.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (drv_valid && evt_if.ready) begin
        pending_status.push_back(station_next(drv_item));
        void'(event_q.pop_front());
      end
      if (!drv_valid || evt_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          drv_valid <= 1'b0;
        end else if (event_q.size() == 0) begin
          drv_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 13);
          drv_valid <= 1'b0;
        end else begin
          drv_valid <= 1'b1;
          drv_item  <= event_q[0];
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got.transmit    = res_if.transmit;
        got.dropped     = res_if.drop_signal;
        got.frames_left = res_if.frames_left;
        got.attempt     = res_if.attempt_count;
        got.wait_left   = res_if.wait_left;
        got.jam         = res_if.jam_flag;
        got.collisions  = res_if.collision_total;
        got.drops       = res_if.drop_total;
        got.frame_start = res_if.frame_start;
        if (pending_status.size() == 0) begin
          if (mismatches < ReportMax)
            $display("result with nothing pending: %s", show_status(got));
          mismatches++;
        end else begin
          want = pending_status.pop_front();
          if (got !== want) begin
            if (mismatches < ReportMax)
              $display("status differs\n  exp %s\n  got %s", show_status(want), show_status(got));
            mismatches++;
          end
        end
      end
      // receiver stalls
      if (stall_left > 0) begin
        stall_left--;
        res_rdy <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 13);
        res_rdy <= 1'b0;
      end else begin
        res_rdy <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("csma_cd_station_backoff: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : stim
    logic [AttemptW-1:0] lim;
    logic [ThreshW-1:0]  thr;
    int                  fc;
    int                  budget;
    int                  made;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults: no frames queued, so ticks and advances do nothing
    @(negedge clk_i);
    add_event(OP_SLOT,      1'b0, 16'h0000, 15'h0000, 32'h0000_0000);
    add_event(OP_ADVANCE,   1'b1, 16'hFFFF, 15'h7FFF, 32'hFFFF_FFFF);
    add_event(OP_COLLISION, 1'b0, 16'h0000, 15'h7FFF, 32'h0000_0001);
    add_event(OP_SUCCESS,   1'b1, 16'h8000, 15'h0000, 32'h8000_0000);
    drain();

    // three frames, threshold above full scale, small limit
    write_reg(CFG_FRAME_COUNT, 17'd3);
    write_reg(CFG_PERSIST_THRESHOLD, 17'h1FFFF);
    write_reg(CFG_BACKOFF_LIMIT, 17'd2);
    @(negedge clk_i);
    add_event(OP_SLOT,      1'b0, 16'hFFFF, 15'h0000, 32'h0000_0010);
    add_event(OP_SLOT,      1'b0, 16'hFFFF, 15'h0000, 32'h0000_0011);
    add_event(OP_COLLISION, 1'b0, 16'h0000, 15'h7FFF, 32'h0000_0012);
    add_event(OP_SLOT,      1'b1, 16'h0000, 15'h0003, 32'h0000_0013);
    add_event(OP_SLOT,      1'b1, 16'h0000, 15'h0003, 32'h0000_0014);
    add_event(OP_SLOT,      1'b1, 16'h0000, 15'h0003, 32'h0000_0015);
    repeat (3) add_event(OP_SLOT, 1'b1, 16'h0000, 15'h0000, 32'h0000_0016);
    add_event(OP_COLLISION, 1'b0, 16'h0000, 15'h0000, 32'h0000_0017);
    add_event(OP_COLLISION, 1'b0, 16'h0000, 15'h7FFF, 32'h0000_0018);
    // run out the drop cooldown, one slot of backoff wait, then a success
    repeat (5) add_event(OP_SLOT, 1'b0, 16'h0000, 15'h0000, 32'h0000_0019);
    add_event(OP_SLOT,      1'b0, 16'h0000, 15'h0000, 32'h0000_001A);
    add_event(OP_SUCCESS,   1'b0, 16'h0000, 15'h0000, 32'hFFFF_FFFF);
    add_event(OP_ADVANCE,   1'b0, 16'h0000, 15'h0000, 32'h0000_0000);
    add_event(OP_ADVANCE,   1'b1, 16'hFFFF, 15'h7FFF, 32'h5A5A_5A5A);
    drain();

    // random phases over a range of settings
    for (int ph = 0; ph < 8; ph++) begin
      fc = int'(head_q) + $urandom_range(30, 120);
      if (fc > 255) fc = 255;
      budget = 120;
      case (ph)
        0: begin
          lim = 4'd0;
          thr = 17'd0;
        end
        1: begin
          lim = 4'd15;
          thr = 17'd65536;
          fc  = 255;
        end
        2: begin
          // frame count below the head of line
          lim    = 4'd1;
          thr    = 17'd32768;
          fc     = int'(head_q) / 2;
          budget = 40;
        end
        3: begin
          lim = 4'd3;
          thr = 17'h1FFFF;
        end
        default: begin
          lim = 4'($urandom_range(1, 6));
          thr = 17'($urandom_range(4096, 65536));
        end
      endcase
      write_reg(CFG_BACKOFF_LIMIT, CfgDataW'(lim));
      write_reg(CFG_PERSIST_THRESHOLD, CfgDataW'(thr));
      write_reg(CFG_FRAME_COUNT, CfgDataW'(fc));
      idle_on = (ph != 3);
      @(negedge clk_i);
      made = 0;
      while (made < budget) made += make_episode();
      drain();
    end

    // last part, no idling: every backoff drops, full frame queue
    idle_on = 1'b0;
    write_reg(CFG_BACKOFF_LIMIT, CfgDataW'(4'd0));
    write_reg(CFG_PERSIST_THRESHOLD, CfgDataW'(17'd65536));
    write_reg(CFG_FRAME_COUNT, CfgDataW'(8'd255));
    @(negedge clk_i);
    made = 0;
    while (made < 90) made += make_episode();
    drain();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("csma_cd_station_backoff: match");
    end else begin
      $display("csma_cd_station_backoff: mismatch");
    end
    $finish;
  end

endmodule
